// File: hdl/sjfq_pkg.sv
// shared types and constants for the shortest-job-first ready queue
// used by sjfq_cell and shortest_job_first_ready_queue_core; no dependencies
package sjfq_pkg;

  // field widths
  localparam int unsigned OpW         = 2;
  localparam int unsigned IdW         = 16;
  localparam int unsigned BurstW      = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CountW      = 7;
  localparam int unsigned DefQueueDepth = 64;

  // packed stream widths, rounded up to whole bytes
  localparam int unsigned InDataW  = ((OpW + IdW + BurstW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((StatusW + IdW + BurstW + CountW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // one queue entry
  typedef struct packed {
    logic              valid;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
  } slot_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic              apply;
    op_e               op;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
  } cmd_t;

endpackage

// File: hdl/sjfq_cell.sv
// one cell of the sorted queue chain: holds a single entry and shifts with its neighbors
// depends on sjfq_pkg
module sjfq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sjfq_pkg::cmd_t  cmd_i,
  input  sjfq_pkg::slot_t left_i,
  input  logic           left_ins_i,
  input  logic           left_hit_i,
  input  sjfq_pkg::slot_t right_i,
  output sjfq_pkg::slot_t slot_o,
  output logic           ins_o,
  output logic           hit_o
);
  import sjfq_pkg::*;

  logic              valid_q, valid_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [BurstW-1:0] burst_q, burst_d;

  assign slot_o = '{valid: valid_q, id: id_q, burst: burst_q};

  // new job goes at or before this cell when it is empty or holds a longer job
  assign ins_o = !valid_q || (burst_q > cmd_i.burst);

  // first matching id at or before this cell
  assign hit_o = left_hit_i || (valid_q && (id_q == cmd_i.id));

  // next entry from the broadcast operation and the neighbors
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    burst_d = burst_q;
    if (cmd_i.apply) begin
      case (cmd_i.op)
        OP_INSERT: begin
          if (left_ins_i) begin
            valid_d = left_i.valid;
            id_d    = left_i.id;
            burst_d = left_i.burst;
          end else if (ins_o) begin
            valid_d = 1'b1;
            id_d    = cmd_i.id;
            burst_d = cmd_i.burst;
          end
        end
        OP_POP: begin
          valid_d = right_i.valid;
          id_d    = right_i.id;
          burst_d = right_i.burst;
        end
        OP_REMOVE: begin
          if (hit_o) begin
            valid_d = right_i.valid;
            id_d    = right_i.id;
            burst_d = right_i.burst;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    burst_q <= burst_d;
  end

endmodule

// File: hdl/shortest_job_first_ready_queue_core.sv
// top level of the shortest-job-first ready queue: stream ports, command stage,
// cell chain and result register; depends on sjfq_pkg and sjfq_cell
//
// Jobs (16-bit id, 32-bit burst time) are kept in a chain of QUEUE_DEPTH cells,
// sorted by burst time with ties in arrival order. Each input beat is one
// operation: insert, pop the shortest job, or remove by id; code 3 does nothing.
// Every beat gives exactly one result beat with status, popped job and count.
// An accepted beat is latched in the command stage and executed by all cells
// together once the result register is free or being read, which loads the
// result register. A new beat is taken in the same cycle the previous command
// executes, so the block sustains one operation per cycle while results are
// taken. Remove finds the first matching id through a flag that ripples along
// the chain, which sets the critical path for deep queues. No clearing pass
// is needed after reset.
module shortest_job_first_ready_queue_core #(
  parameter int unsigned QUEUE_DEPTH = sjfq_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation [1:0], job_id [17:2], burst_time [49:18], zero fill above
  input  logic [sjfq_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status [1:0], out_id [17:2], out_time [49:18], queue_count [56:50], zero fill above
  output logic [sjfq_pkg::OutDataW-1:0] m_axis_tdata
);
  import sjfq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // command stage
  logic              cmd_valid_q;
  op_e               cmd_op_q;
  logic [IdW-1:0]    cmd_id_q;
  logic [BurstW-1:0] cmd_burst_q;
  logic              exec;
  logic              in_beat;

  // chain and count
  cmd_t              cmd;
  slot_t             slot  [QUEUE_DEPTH];
  logic              ins   [QUEUE_DEPTH];
  logic              hit   [QUEUE_DEPTH];
  logic [CntW-1:0]   count_q, count_d;
  logic              full, empty, found;

  // result register
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [IdW-1:0]      out_id_q, out_id_d;
  logic [BurstW-1:0]   out_time_q, out_time_d;
  logic [CountW-1:0]   out_count_q;

  // handshakes
  assign exec          = cmd_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !cmd_valid_q || exec;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  // command valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      cmd_valid_q <= s_axis_tvalid;
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      cmd_op_q    <= op_e'(s_axis_tdata[OpW-1:0]);
      cmd_id_q    <= s_axis_tdata[OpW +: IdW];
      cmd_burst_q <= s_axis_tdata[OpW+IdW +: BurstW];
    end
  end

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign found = hit[QUEUE_DEPTH-1];

  // broadcast to the cells, with dropped inserts and empty pops held off
  always_comb begin
    cmd.op    = cmd_op_q;
    cmd.id    = cmd_id_q;
    cmd.burst = cmd_burst_q;
    cmd.apply = exec && !((cmd_op_q == OP_INSERT) && full)
                     && !((cmd_op_q == OP_POP) && empty);
  end

  // cell chain
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    slot_t left_slot, right_slot;
    logic  left_ins, left_hit;

    if (k == 0) begin : g_head
      assign left_slot = '0;
      assign left_ins  = 1'b0;
      assign left_hit  = 1'b0;
    end else begin : g_mid
      assign left_slot = slot[k-1];
      assign left_ins  = ins[k-1];
      assign left_hit  = hit[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign right_slot = '0;
    end else begin : g_body
      assign right_slot = slot[k+1];
    end

    sjfq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .left_i     (left_slot),
      .left_ins_i (left_ins),
      .left_hit_i (left_hit),
      .right_i    (right_slot),
      .slot_o     (slot[k]),
      .ins_o      (ins[k]),
      .hit_o      (hit[k])
    );
  end

  // result and count update
  always_comb begin
    status_d   = ST_OK;
    out_id_d   = '0;
    out_time_d = '0;
    count_d    = count_q;
    case (cmd_op_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          out_id_d   = slot[0].id;
          out_time_d = slot[0].burst;
          count_d    = count_q - CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  // entry count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q    <= status_d;
      out_id_q    <= out_id_d;
      out_time_q  <= out_time_d;
      out_count_q <= CountW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'({out_count_q, out_time_q, out_id_q, status_q});

endmodule

// File: sim/shortest_job_first_ready_queue_core_test.sv
// self-checking testbench for shortest_job_first_ready_queue_core: directed table,
// then random operations checked against a shadow of the sorted queue
// depends on sjfq_pkg and the queue rtl
module shortest_job_first_ready_queue_core_test;
  import sjfq_pkg::*;

  localparam int unsigned QDepth    = DefQueueDepth;
  localparam int unsigned InFillW   = InDataW - OpW - IdW - BurstW;
  localparam int unsigned StallMax  = 2000;
  localparam int unsigned DrainWait = 8;
  localparam int unsigned PhaseOps  = 265;

  // one result beat, split into fields
  typedef struct {
    status_e           status;
    logic [IdW-1:0]    job;
    logic [BurstW-1:0] burst;
    logic [CountW-1:0] count;
  } sched_result_t;

  // directed row; typed rows carry their own expected result
  typedef struct {
    op_e               op;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    int                reps;
    bit                typed;
    status_e           status;
    logic [IdW-1:0]    job;
    logic [BurstW-1:0] out_burst;
    logic [CountW-1:0] count;
  } plan_row_t;

  localparam int unsigned PlanRows = 18;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  // shadow of the sorted queue
  logic [IdW-1:0]    shadow_id    [QDepth];
  logic [BurstW-1:0] shadow_burst [QDepth];
  int unsigned       shadow_count = 0;

  sched_result_t pending_results[$];
  int unsigned   errors = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   take_stall_pct = 0;
  int unsigned   quiet_cycles = 0;

  plan_row_t plan [PlanRows] = '{
    '{OP_POP,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     16'h0, 32'h0, 7'd0},
    '{OP_REMOVE, 16'h1234, 32'h0000_0000,  1, 1'b1, ST_NOT_FOUND, 16'h0, 32'h0, 7'd0},
    '{OP_NOP,    16'hFFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF,  1, 1'b1, ST_OK,        16'h0, 32'h0, 7'd1},
    '{OP_INSERT, 16'h0000, 32'h0000_0000,  1, 1'b1, ST_OK,        16'h0, 32'h0, 7'd2},
    '{OP_INSERT, 16'h5555, 32'hAAAA_AAAA,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 16'hAAAA, 32'h5555_5555,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    // equal burst, must leave after the previous one
    '{OP_INSERT, 16'h0101, 32'h5555_5555,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_POP,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_OK,        16'h0, 32'h0, 7'd4},
    '{OP_POP,    16'h0000, 32'h0000_0000,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_REMOVE, 16'h5555, 32'h0000_0000,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_REMOVE, 16'h5555, 32'h0000_0000,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_NOP,    16'h0000, 32'h0000_0000,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    // fill up with equal bursts
    '{OP_INSERT, 16'h1000, 32'h0000_0100, 62, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_INSERT, 16'h7777, 32'h0000_0005,  1, 1'b1, ST_FULL,      16'h0, 32'h0, 7'd64},
    '{OP_REMOVE, 16'hFFFF, 32'h0000_0000,  1, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_POP,    16'h0000, 32'h0000_0000, 63, 1'b0, ST_OK,        16'h0, 32'h0, 7'd0},
    '{OP_POP,    16'h0000, 32'h0000_0000,  1, 1'b1, ST_EMPTY,     16'h0, 32'h0, 7'd0}
  };

  shortest_job_first_ready_queue_core #(
    .QUEUE_DEPTH(QDepth)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // close the hole at pos, shifting later jobs toward the head
  function automatic void drop_slot(int unsigned pos);
    for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
      shadow_id[k]    = shadow_id[k + 1];
      shadow_burst[k] = shadow_burst[k + 1];
    end
    shadow_count--;
  endfunction

  // apply one operation to the shadow queue and return the result it yields
  function automatic sched_result_t schedule_op(op_e op, logic [IdW-1:0] id,
                                                logic [BurstW-1:0] burst);
    sched_result_t r;
    int unsigned   pos;
    int            hit;
    r.status = ST_OK;
    r.job    = '0;
    r.burst  = '0;
    hit      = -1;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= QDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = shadow_count;
          while (pos > 0 && shadow_burst[pos - 1] > burst) begin
            shadow_id[pos]    = shadow_id[pos - 1];
            shadow_burst[pos] = shadow_burst[pos - 1];
            pos--;
          end
          shadow_id[pos]    = id;
          shadow_burst[pos] = burst;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.job   = shadow_id[0];
          r.burst = shadow_burst[0];
          drop_slot(0);
        end
      end
      OP_REMOVE: begin
        for (int unsigned k = 0; k < shadow_count; k++) begin
          if (hit < 0 && shadow_id[k] == id) hit = k;
        end
        if (hit < 0) r.status = ST_NOT_FOUND;
        else drop_slot(hit);
      end
      default: ;
    endcase
    r.count = shadow_count[CountW-1:0];
    return r;
  endfunction

  // drive one operation beat, wait for it to be taken, then predict
  task automatic issue_op(input op_e op, input logic [IdW-1:0] id,
                          input logic [BurstW-1:0] burst, output sched_result_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{InFillW{1'b0}}, burst, id, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = schedule_op(op, id, burst);
  endtask

  // result side: random stalls and field checks
  always @(posedge clk_i) begin : take_results
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          errors++;
        end
        if (m_axis_tdata[17:2] !== want.job) begin
          $error("out_id: expected %h, got %h", want.job, m_axis_tdata[17:2]);
          errors++;
        end
        if (m_axis_tdata[49:18] !== want.burst) begin
          $error("out_time: expected %h, got %h", want.burst, m_axis_tdata[49:18]);
          errors++;
        end
        if (m_axis_tdata[56:50] !== want.count) begin
          $error("queue_count: expected %0d, got %0d", want.count, m_axis_tdata[56:50]);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= take_stall_pct);
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallMax) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    sched_result_t     r;
    sched_result_t     typed_result;
    op_e               op;
    logic [IdW-1:0]    id;
    logic [BurstW-1:0] burst;
    int unsigned       roll;
    int unsigned       seg_left;
    bit                filling;
    int unsigned       phase_send [4];
    int unsigned       phase_stall [4];

    phase_send  = '{0, 73, 0, 15};
    phase_stall = '{0, 0, 73, 15};
    seg_left    = 0;
    filling     = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        issue_op(plan[i].op, plan[i].id + k[IdW-1:0], plan[i].burst, r);
        if (plan[i].typed) begin
          typed_result.status = plan[i].status;
          typed_result.job    = plan[i].job;
          typed_result.burst  = plan[i].out_burst;
          typed_result.count  = plan[i].count;
          pending_results.push_back(typed_result);
        end else begin
          pending_results.push_back(r);
        end
      end
    end

    // random operations, swinging between filling and draining the queue
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      take_stall_pct = phase_stall[p];
      for (int n = 0; n < PhaseOps; n++) begin
        if (seg_left == 0) begin
          filling  = !filling;
          seg_left = $urandom_range(160, 40);
        end
        seg_left--;
        roll = $urandom_range(99);
        if (filling) begin
          op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_POP :
               (roll < 95) ? OP_REMOVE : OP_NOP;
        end else begin
          op = (roll < 20) ? OP_INSERT : (roll < 70) ? OP_POP :
               (roll < 95) ? OP_REMOVE : OP_NOP;
        end
        // ids from a small pool give duplicates for remove to pick among
        if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(99) < 80) begin
          id = shadow_id[$urandom_range(shadow_count - 1)];
        end else if ($urandom_range(1) == 1) begin
          id = IdW'($urandom_range(15));
        end else begin
          id = IdW'($urandom_range(16'hFFFF));
        end
        case ($urandom_range(4))
          0, 1:    burst = $urandom_range(7);
          2, 3:    burst = $urandom();
          default: burst = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
        issue_op(op, id, burst, r);
        pending_results.push_back(r);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
